### design/mrt_pkg.sv
// shared types and constants for the miller-rabin witness round block
`default_nettype none

package mrt_pkg;

   // field widths of the stream beats
   localparam int CAND_BITS         = 63;
   localparam int WIT_BITS          = 63;
   localparam int REQ_DATA_BITS     = 128;
   localparam int RSP_DATA_BITS     = 8;
   localparam int DEFAULT_WORD_BITS = 64;

   // operand routing for the modular multiplier
   typedef enum logic [1:0] {
      MUL_REDUCE = 2'd0,   // 1 * witness, folds the witness below n
      MUL_SQUARE = 2'd1,   // res * res
      MUL_BASE   = 2'd2    // witness * res
   } mul_op_type;

   // source of the verdict bit
   typedef enum logic [1:0] {
      VERD_SPECIAL = 2'd0, // small or even candidate
      VERD_RES_ONE = 2'd1, // final value equals one
      VERD_FAIL    = 2'd2  // nontrivial square root of one found
   } verdict_sel_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic            load;
      logic            split;
      logic            mul_start;
      mul_op_type      mul_op;
      logic            wr_a;
      logic            wr_res;
      logic            exp_step;
      logic            chain_step;
      logic            set_verdict;
      verdict_sel_type verdict_sel;
      logic            emit;
   } mrt_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic special;
      logic x_lsb;
      logic x_msb;
      logic exp_last;
      logic t_zero;
      logic sqrt_fail;
      logic mul_done;
   } mrt_status_type;

endpackage

`default_nettype wire

### design/miller_rabin_witness_test_top.sv
// top level of the miller-rabin witness round block
//
//  channel  direction  beat contents (lsb first)
//  req      in         candidate[62:0], witness[125:63], zero pad [127:126]
//  rsp      out        probably_prime[0], zero pad [7:1]
//
// small or even candidates skip straight to the verdict; the next req beat is taken only
// once the block is back in idle. odd candidates run the split, the reduction of the
// witness, the square-and-multiply over the odd part and the squaring chain, which
// ends early when a nontrivial root of one is found.
// reset is synchronous; there is no memory, so nothing needs clearing.
// a waiting rsp beat does not block the next req beat; that item holds before its result.
`default_nettype none

module miller_rabin_witness_test_top #(
   parameter int WORD_BITS = mrt_pkg::DEFAULT_WORD_BITS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // candidate[62:0], witness[125:63], zero[127:126]
   input  wire logic [mrt_pkg::REQ_DATA_BITS-1:0] req_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // probably_prime[0], zero[7:1]
   output logic [mrt_pkg::RSP_DATA_BITS-1:0]      rsp_tdata
);
   import mrt_pkg::*;

   mrt_cmd_type    cmd;
   mrt_status_type status;
   logic           verdict;

   // unpack the request beat
   logic [CAND_BITS-1:0] candidate;
   logic [WIT_BITS-1:0]  witness;

   assign candidate = req_tdata[CAND_BITS-1:0];
   assign witness   = req_tdata[CAND_BITS+WIT_BITS-1:CAND_BITS];

   mrt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mrt_dpath #(
      .WORD_BITS (WORD_BITS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .candidate      (candidate),
      .witness        (witness),
      .cmd            (cmd),
      .status         (status),
      .probably_prime (verdict)
   );

   // pack the response beat
   assign rsp_tdata = {{(RSP_DATA_BITS-1){1'b0}}, verdict};

endmodule

`default_nettype wire

### design/mrt_modmul.sv
// bit-serial interleaved modular multiplier, msb of the multiplier first
`default_nettype none

module mrt_modmul #(
   parameter int WORD_BITS = mrt_pkg::DEFAULT_WORD_BITS
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [WORD_BITS-2:0] multiplicand,
   input  wire logic [WORD_BITS-2:0] multiplier,
   input  wire logic [WORD_BITS-2:0] modulus,
   output logic                      done,
   output logic [WORD_BITS-2:0]      product
);
   import mrt_pkg::*;

   localparam int OPW = WORD_BITS - 1;
   localparam int SW  = OPW + 2;
   localparam int CW  = $clog2(OPW);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [OPW-1:0] acc_ff, acc_in;
   logic [OPW-1:0] md_ff, md_in;
   logic [OPW-1:0] mr_ff, mr_in;

   logic [SW-1:0] sum;
   logic [SW-1:0] mod1;
   logic [SW-1:0] mod2;
   logic [SW-1:0] folded;

   // one step: acc = (2*acc + bit*md) mod n, sum stays below 3n
   always_comb begin
      mod1 = {2'b00, modulus};
      mod2 = {1'b0, modulus, 1'b0};
      sum  = {1'b0, acc_ff, 1'b0} + (mr_ff[OPW-1] ? {2'b00, md_ff} : '0);
      if (sum >= mod2) begin
         folded = sum - mod2;
      end else if (sum >= mod1) begin
         folded = sum - mod1;
      end else begin
         folded = sum;
      end
   end

   // next state of the step sequencer
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      md_in   = md_ff;
      mr_in   = mr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         acc_in  = '0;
         md_in   = multiplicand;
         mr_in   = multiplier;
      end else if (busy_ff) begin
         acc_in = folded[OPW-1:0];
         mr_in  = {mr_ff[OPW-2:0], 1'b0};
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(OPW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // operand and accumulator registers
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      md_ff  <= md_in;
      mr_ff  <= mr_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

`default_nettype wire

### design/mrt_dpath.sv
// datapath: candidate, exponent, power value, counters and verdict
`default_nettype none

module mrt_dpath #(
   parameter int WORD_BITS = mrt_pkg::DEFAULT_WORD_BITS
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [mrt_pkg::CAND_BITS-1:0]  candidate,
   input  wire logic [mrt_pkg::WIT_BITS-1:0]   witness,
   input  wire mrt_pkg::mrt_cmd_type           cmd,
   output mrt_pkg::mrt_status_type             status,
   output logic                                probably_prime
);
   import mrt_pkg::*;

   localparam int OPW = WORD_BITS - 1;
   localparam int TW  = $clog2(OPW);
   localparam logic [OPW-1:0] ONE = OPW'(1);
   localparam logic [OPW-1:0] TWO = OPW'(2);

   logic [OPW-1:0] n_ff, n_in;
   logic [OPW-1:0] a_ff, a_in;
   logic [OPW-1:0] x_ff, x_in;
   logic [OPW-1:0] res_ff, res_in;
   logic [TW-1:0]  t_ff, t_in;
   logic [TW-1:0]  ecnt_ff, ecnt_in;
   logic           verdict_ff, verdict_in;
   logic           rsp_bit_ff, rsp_bit_in;

   logic [OPW-1:0] md;
   logic [OPW-1:0] mr;
   logic           mul_done;
   logic [OPW-1:0] product;

   // operand routing into the multiplier
   always_comb begin
      case (cmd.mul_op)
         MUL_REDUCE: begin
            md = ONE;
            mr = a_ff;
         end
         MUL_SQUARE: begin
            md = res_ff;
            mr = res_ff;
         end
         MUL_BASE: begin
            md = a_ff;
            mr = res_ff;
         end
         default: begin
            md = res_ff;
            mr = res_ff;
         end
      endcase
   end

   mrt_modmul #(
      .WORD_BITS (WORD_BITS)
   ) u_modmul (
      .clock        (clock),
      .reset        (reset),
      .start        (cmd.mul_start),
      .multiplicand (md),
      .multiplier   (mr),
      .modulus      (n_ff),
      .done         (mul_done),
      .product      (product)
   );

   // register updates driven by the controller
   always_comb begin
      n_in       = n_ff;
      a_in       = a_ff;
      x_in       = x_ff;
      res_in     = res_ff;
      t_in       = t_ff;
      ecnt_in    = ecnt_ff;
      verdict_in = verdict_ff;
      rsp_bit_in = rsp_bit_ff;
      if (cmd.load) begin
         n_in    = candidate[OPW-1:0];
         a_in    = witness[OPW-1:0];
         x_in    = candidate[OPW-1:0] - ONE;
         res_in  = ONE;
         t_in    = '0;
         ecnt_in = '0;
      end
      if (cmd.split) begin
         x_in = {1'b0, x_ff[OPW-1:1]};
         t_in = t_ff + TW'(1);
      end
      if (cmd.wr_a) begin
         a_in = product;
      end
      if (cmd.wr_res) begin
         res_in = product;
      end
      if (cmd.exp_step) begin
         x_in    = {x_ff[OPW-2:0], 1'b0};
         ecnt_in = ecnt_ff + TW'(1);
      end
      if (cmd.chain_step) begin
         t_in = t_ff - TW'(1);
      end
      if (cmd.set_verdict) begin
         case (cmd.verdict_sel)
            VERD_SPECIAL: verdict_in = (n_ff == TWO);
            VERD_RES_ONE: verdict_in = (res_ff == ONE);
            VERD_FAIL:    verdict_in = 1'b0;
            default:      verdict_in = 1'b0;
         endcase
      end
      if (cmd.emit) begin
         rsp_bit_in = verdict_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      n_ff       <= n_in;
      a_ff       <= a_in;
      x_ff       <= x_in;
      res_ff     <= res_in;
      t_ff       <= t_in;
      ecnt_ff    <= ecnt_in;
      verdict_ff <= verdict_in;
      rsp_bit_ff <= rsp_bit_in;
   end

   // status toward the controller
   always_comb begin
      status.special   = (n_ff < TWO) || !n_ff[0];
      status.x_lsb     = x_ff[0];
      status.x_msb     = x_ff[OPW-1];
      status.exp_last  = (ecnt_ff == TW'(OPW - 1));
      status.t_zero    = (t_ff == '0);
      status.sqrt_fail = (product == ONE) && (res_ff != ONE) && (res_ff != (n_ff - ONE));
      status.mul_done  = mul_done;
   end

   assign probably_prime = rsp_bit_ff;

endmodule

`default_nettype wire

### design/mrt_ctrl.sv
// controller: sequences split, reduction, exponentiation and squaring chain
`default_nettype none

module mrt_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   input  wire mrt_pkg::mrt_status_type status,
   output mrt_pkg::mrt_cmd_type         cmd
);
   import mrt_pkg::*;

   typedef enum logic [11:0] {
      ST_IDLE       = 12'b0000_0000_0001,
      ST_CHECK      = 12'b0000_0000_0010,
      ST_SPLIT      = 12'b0000_0000_0100,
      ST_REDUCE     = 12'b0000_0000_1000,
      ST_SQ_START   = 12'b0000_0001_0000,
      ST_SQ_WAIT    = 12'b0000_0010_0000,
      ST_BIT        = 12'b0000_0100_0000,
      ST_MUL_WAIT   = 12'b0000_1000_0000,
      ST_STEP       = 12'b0001_0000_0000,
      ST_CHAIN      = 12'b0010_0000_0000,
      ST_CHAIN_WAIT = 12'b0100_0000_0000,
      ST_FINISH     = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.special) begin
               cmd.set_verdict = 1'b1;
               cmd.verdict_sel = VERD_SPECIAL;
               state_in        = ST_FINISH;
            end else begin
               state_in = ST_SPLIT;
            end
         end
         // strip trailing zeros of n-1, then fold the witness below n
         ST_SPLIT: begin
            if (!status.x_lsb) begin
               cmd.split = 1'b1;
            end else begin
               cmd.mul_start = 1'b1;
               cmd.mul_op    = MUL_REDUCE;
               state_in      = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (status.mul_done) begin
               cmd.wr_a = 1'b1;
               state_in = ST_SQ_START;
            end
         end
         // left-to-right square-and-multiply over the odd part
         ST_SQ_START: begin
            cmd.mul_start = 1'b1;
            cmd.mul_op    = MUL_SQUARE;
            state_in      = ST_SQ_WAIT;
         end
         ST_SQ_WAIT: begin
            if (status.mul_done) begin
               cmd.wr_res = 1'b1;
               state_in   = ST_BIT;
            end
         end
         ST_BIT: begin
            if (status.x_msb) begin
               cmd.mul_start = 1'b1;
               cmd.mul_op    = MUL_BASE;
               state_in      = ST_MUL_WAIT;
            end else begin
               state_in = ST_STEP;
            end
         end
         ST_MUL_WAIT: begin
            if (status.mul_done) begin
               cmd.wr_res = 1'b1;
               state_in   = ST_STEP;
            end
         end
         ST_STEP: begin
            cmd.exp_step = 1'b1;
            state_in     = status.exp_last ? ST_CHAIN : ST_SQ_START;
         end
         // repeated squaring, watching for a nontrivial root of one
         ST_CHAIN: begin
            if (status.t_zero) begin
               cmd.set_verdict = 1'b1;
               cmd.verdict_sel = VERD_RES_ONE;
               state_in        = ST_FINISH;
            end else begin
               cmd.mul_start = 1'b1;
               cmd.mul_op    = MUL_SQUARE;
               state_in      = ST_CHAIN_WAIT;
            end
         end
         ST_CHAIN_WAIT: begin
            if (status.mul_done) begin
               if (status.sqrt_fail) begin
                  cmd.set_verdict = 1'b1;
                  cmd.verdict_sel = VERD_FAIL;
                  state_in        = ST_FINISH;
               end else begin
                  cmd.wr_res     = 1'b1;
                  cmd.chain_step = 1'b1;
                  state_in       = ST_CHAIN;
               end
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output beat register
   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

### design/mrt_checker.sv
// port-level checks for the miller-rabin witness round block
`default_nettype none

module mrt_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tvalid,
   input wire logic                              req_tready,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [mrt_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);
   import mrt_pkg::*;

   logic [1:0] pending_ff, pending_in;
   logic       req_beat;
   logic       rsp_beat;

   // count of items taken but not yet delivered
   assign req_beat = req_tvalid && req_tready;
   assign rsp_beat = rsp_tvalid && rsp_tready;

   always_comb begin
      pending_in = pending_ff + {1'b0, req_beat} - {1'b0, rsp_beat};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   // no response without an item in flight
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      pending_ff == 2'd0 |-> !rsp_tvalid)
      else $error("rsp beat with no item outstanding");

   // one item in work plus one waiting result is the limit
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      pending_ff == 2'd2 |-> !req_tready)
      else $error("req taken with two items outstanding");

   // padding above the verdict stays zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_DATA_BITS-1:1] == '0)
      else $error("rsp padding not zero");

endmodule

bind miller_rabin_witness_test_top mrt_checker u_mrt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

### tb/miller_rabin_witness_test_top_tb.sv
// self-checking testbench for the miller-rabin witness round block
`timescale 1ns / 1ps

module miller_rabin_witness_test_top_tb;

   localparam int          RESET_CYCLES = 7;
   localparam int          RANDOM_ITEMS = 72;
   localparam int          QUIET_ITEMS  = 20;
   localparam int          HOLD_CYCLES  = 300;
   localparam int          TAIL_CYCLES  = 60;
   localparam longint      CYCLE_LIMIT  = 5_000_000;
   localparam logic [62:0] OPERAND_MAX  = '1;

   // verdict predictor and store of expected verdicts
   class verdict_scoreboard;
      bit expected_verdicts[$];
      int failures;

      function new();
         failures = 0;
      endfunction

      // shift-add modular product, reductions on r >= m
      function logic [63:0] mod_product(logic [63:0] a, logic [63:0] b, logic [63:0] m);
         logic [63:0] acc;
         logic [63:0] addend;
         logic [63:0] bits;
         acc    = '0;
         addend = a % m;
         bits   = b % m;
         while (bits != 0) begin
            if (bits[0]) begin
               acc = acc + addend;
               if (acc >= m) acc = acc - m;
            end
            addend = addend << 1;
            if (addend >= m) addend = addend - m;
            bits = bits >> 1;
         end
         return acc;
      endfunction

      function logic [63:0] mod_power(logic [63:0] base, logic [63:0] e, logic [63:0] m);
         logic [63:0] acc;
         logic [63:0] sq;
         acc = 64'd1 % m;
         sq  = base % m;
         while (e != 0) begin
            if (e[0]) acc = mod_product(acc, sq, m);
            sq = mod_product(sq, sq, m);
            e  = e >> 1;
         end
         return acc;
      endfunction

      function bit witness_round(logic [63:0] n, logic [63:0] a);
         logic [63:0] odd_part;
         logic [63:0] cur;
         logic [63:0] prev;
         int          twos;
         if (n < 2) return 1'b0;
         if (n == 2) return 1'b1;
         if (!n[0]) return 1'b0;
         odd_part = n - 1;
         twos     = 0;
         while (!odd_part[0]) begin
            odd_part = odd_part >> 1;
            twos++;
         end
         cur  = mod_power(a, odd_part, n);
         prev = cur;
         for (int i = 0; i < twos; i++) begin
            cur = mod_product(cur, cur, n);
            // nontrivial square root of one
            if (cur == 1 && prev != 1 && prev != n - 1) return 1'b0;
            prev = cur;
         end
         return cur == 1;
      endfunction

      function void note_request(logic [62:0] cand, logic [62:0] wit);
         bit verdict;
         verdict           = witness_round({1'b0, cand}, {1'b0, wit});
         expected_verdicts = {expected_verdicts, verdict};
      endfunction

      function void check_response(logic got);
         bit want;
         if (expected_verdicts.size() == 0) begin
            $error("probably_prime beat with nothing expected: actual %0d", got);
            failures++;
         end else begin
            want = expected_verdicts.pop_front();
            if (got !== want) begin
               $error("probably_prime mismatch: expected %0d, actual %0d", want, got);
               failures++;
            end
         end
      endfunction

      function int pending();
         return expected_verdicts.size();
      endfunction
   endclass

   logic                              clock      = 1'b0;
   logic                              reset      = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [mrt_pkg::REQ_DATA_BITS-1:0] req_tdata  = '0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [mrt_pkg::RSP_DATA_BITS-1:0] rsp_tdata;

   verdict_scoreboard sb;
   bit                hold_request = 1'b0;
   bit                quiet_tail   = 1'b0;
   longint            cycle_count  = 0;

   miller_rabin_witness_test_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata[0]);
   end

   // result receiver: random stall bursts, one long hold-off on request
   initial begin
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("miller_rabin_witness_test_top regression: fail");
      $finish;
   end

   function automatic logic [62:0] rand_word();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[62:0];
   endfunction

   // odd numbers of interest: primes with short and long runs of twos, pseudoprimes
   function automatic logic [62:0] known_odd(int idx);
      case (idx)
         0:       return 63'd9223372036854775783;
         1:       return 63'd2305843009213693951;
         2:       return 63'd998244353;
         3:       return 63'd65537;
         4:       return 63'd4294967291;
         5:       return 63'd3215031751;
         6:       return 63'd561;
         7:       return 63'd2047;
         8:       return 63'd1000000007;
         default: return 63'd97;
      endcase
   endfunction

   // witness for an odd candidate, mostly inside 1 .. n-1
   function automatic logic [62:0] pick_witness(logic [62:0] n);
      case ($urandom_range(0, 7))
         0:       return rand_word();
         1:       return n - 1;
         2:       return 63'd1;
         3:       return n;
         default: return (rand_word() % (n - 1)) + 1;
      endcase
   endfunction

   // offer one req beat and hold it until taken; valid stays high
   task automatic send_req(input logic [62:0] cand, input logic [62:0] wit);
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, wit, cand};
      do @(posedge clock); while (!req_tready);
      sb.note_request(cand, wit);
   endtask

   task automatic idle_sender(input int cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic send_paced(input logic [62:0] cand, input logic [62:0] wit);
      send_req(cand, wit);
      if (!quiet_tail && $urandom_range(0, 3) == 0) idle_sender($urandom_range(1, 5));
   endtask

   task automatic wait_drain();
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // stimulus
   initial begin
      logic [62:0] cand;
      logic [62:0] wit;
      int          kind;
      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: small and even candidates, witness edges, primes and pseudoprimes
      send_paced(63'd0, 63'd5);
      send_paced(63'd1, 63'd1);
      send_paced(63'd2, 63'd0);
      send_paced(63'd2, OPERAND_MAX);
      send_paced(63'd4, 63'd3);
      send_paced(OPERAND_MAX - 1, 63'd3);
      send_paced(63'd3, 63'd0);
      send_paced(63'd3, 63'd1);
      send_paced(63'd3, 63'd2);
      send_paced(63'd3, 63'd3);
      send_paced(63'd5, OPERAND_MAX);
      send_paced(63'd561, 63'd2);
      send_paced(63'd2047, 63'd2);
      send_paced(63'd3215031751, 63'd2);
      send_paced(63'd998244353, 63'd3);
      send_paced(63'd65537, OPERAND_MAX);
      send_paced(known_odd(0), 63'd2);
      send_paced(known_odd(0), known_odd(0) - 1);
      send_paced(OPERAND_MAX, 63'd2);
      send_paced(OPERAND_MAX, OPERAND_MAX);
      send_paced(known_odd(1), known_odd(1) + 1);
      send_paced(63'd1000000007, 63'd0);

      // hold the result side and keep offering quick beats so the block backs up
      hold_request = 1'b1;
      for (int i = 0; i < 6; i++) begin
         cand = rand_word();
         cand[0] = 1'b0;
         send_req((i % 2 == 0) ? cand : 63'($urandom_range(0, 2)), rand_word());
      end
      idle_sender(1);
      wait_drain();

      // random part, mostly odd candidates that run the full round
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i >= RANDOM_ITEMS - QUIET_ITEMS) quiet_tail = 1'b1;
         kind = $urandom_range(0, 19);
         if (kind < 9) begin
            cand = rand_word() | 63'd1;
            if (cand < 3) cand = 63'd3;
            wit = pick_witness(cand);
         end else if (kind < 12) begin
            cand = 63'($urandom_range(3, 255)) | 63'd1;
            wit  = pick_witness(cand);
         end else if (kind < 16) begin
            cand = known_odd($urandom_range(0, 9));
            wit  = pick_witness(cand);
         end else if (kind < 18) begin
            cand = rand_word();
            wit  = rand_word();
         end else begin
            cand = rand_word();
            cand[0] = 1'b0;
            if ($urandom_range(0, 1) == 0) cand = 63'($urandom_range(0, 2));
            wit = rand_word();
         end
         send_paced(cand, wit);
      end

      req_tvalid <= 1'b0;
      wait_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("miller_rabin_witness_test_top regression: pass");
      end else begin
         $display("miller_rabin_witness_test_top regression: fail");
      end
      $finish;
   end

endmodule

### miller_rabin_witness_test_top.f
design/mrt_pkg.sv
design/mrt_modmul.sv
design/mrt_dpath.sv
design/mrt_ctrl.sv
design/miller_rabin_witness_test_top.sv
design/mrt_checker.sv
tb/miller_rabin_witness_test_top_tb.sv
